// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the packet flood filter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PFF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define PFF_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/pff_pkg.sv -----
// Package for the packet flood filter: item and config types, codes, constants.
// No dependencies; used by every module of the block but pff_ram.
package pff_pkg;

    // Default sizes
    localparam int RATE_ENTRIES_DEF  = 8192;
    localparam int BLOCK_ENTRIES_DEF = 1024;
    localparam int TIME_BITS_DEF     = 48;

    // Field widths
    localparam int TICK_W  = 48;
    localparam int STAT_W  = 48;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int SYN_W   = 17;
    localparam int CFG_IDX_W = 3;

    // Hash multiplier (golden ratio)
    localparam logic [ADDR_W-1:0] HASH_MULT = 32'h9E37_79B1;

    localparam logic [STAT_W-1:0] STAT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [SYN_W-1:0]  SYN_MAX  = 17'h1_FFFF;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_LIMIT      = 3'd4;

    // Config reset values
    localparam logic [COUNT_W-1:0] RST_MAX_PER_WINDOW = 16'd100;
    localparam logic [TICK_W-1:0]  RST_WINDOW_TICKS   = 48'd1_000_000_000;
    localparam logic [TICK_W-1:0]  RST_BLOCK_TICKS    = 48'd60_000_000_000;
    localparam logic [15:0]        RST_SYN_THRESHOLD  = 16'd50;
    localparam logic [15:0]        RST_UDP_LIMIT      = 16'd1400;

    // Operation codes
    localparam logic OP_JUDGE = 1'b0;
    localparam logic OP_STAT  = 1'b1;

    // IP protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Drop reasons
    localparam logic [2:0] REASON_NONE  = 3'd0;
    localparam logic [2:0] REASON_BLOCK = 3'd1;
    localparam logic [2:0] REASON_RATE  = 3'd2;
    localparam logic [2:0] REASON_SYN   = 3'd3;
    localparam logic [2:0] REASON_UDP   = 3'd4;

    // Statistic indexes
    localparam logic [1:0] STAT_TOTAL   = 2'd0;
    localparam logic [1:0] STAT_BLOCKED = 2'd1;
    localparam logic [1:0] STAT_SYN     = 2'd2;
    localparam logic [1:0] STAT_UDP     = 2'd3;

    typedef struct packed {
        logic              op;
        logic              is_ipv4;
        logic [ADDR_W-1:0] src_addr;
        logic [7:0]        protocol;
        logic              tcp_complete;
        logic              syn_flag;
        logic              ack_flag;
        logic [15:0]       total_length;
        logic [TICK_W-1:0] now_time;
        logic [1:0]        stat_index;
    } t_in_item;

    typedef struct packed {
        logic              drop;
        logic [2:0]        drop_reason;
        logic [STAT_W-1:0] stat_value;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0] max_per_window;
        logic [TICK_W-1:0]  window_ticks;
        logic [TICK_W-1:0]  block_ticks;
        logic [15:0]        syn_threshold;
        logic [15:0]        udp_length_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DEC,
        ST_DONE
    } t_state;

endpackage

// ----- hdl/pff_hash.sv -----
// Source address hash stage: multiply by the golden-ratio constant, fold halves.
// Depends on pff_pkg (HASH_MULT, ADDR_W).
module pff_hash import pff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_src,
    output logic [ADDR_W-1:0] o_hash
);

    logic [ADDR_W-1:0] r_prod;

    // Low word of the product, registered when an item is taken
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_src * HASH_MULT;
        end
    end

    // Fold upper half into lower half
    assign o_hash = r_prod ^ (r_prod >> 16);

endmodule

// ----- hdl/pff_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module pff_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/pff_ctrl.sv -----
// Verdict sequencer: table clearing, read-compare-decide-write per item,
// statistics, SYN counter and the output register.
// Depends on pff_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pff_ctrl import pff_pkg::*; #(
    parameter int RATE_ENTRIES  = RATE_ENTRIES_DEF,
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF,
    localparam int RATE_AW = $clog2(RATE_ENTRIES),
    localparam int BLK_AW  = $clog2(BLOCK_ENTRIES),
    localparam int RATE_W  = 1 + ADDR_W + TIME_BITS + COUNT_W,
    localparam int BLK_W   = 1 + ADDR_W + TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    // hash stage
    output logic               o_hash_en,
    input  logic [ADDR_W-1:0]  i_hash,
    // rate table
    output logic               o_rate_we,
    output logic [RATE_AW-1:0] o_rate_waddr,
    output logic [RATE_W-1:0]  o_rate_wdata,
    output logic               o_rate_re,
    output logic [RATE_AW-1:0] o_rate_raddr,
    input  logic [RATE_W-1:0]  i_rate_rdata,
    // blocklist table
    output logic               o_blk_we,
    output logic [BLK_AW-1:0]  o_blk_waddr,
    output logic [BLK_W-1:0]   o_blk_wdata,
    output logic               o_blk_re,
    output logic [BLK_AW-1:0]  o_blk_raddr,
    input  logic [BLK_W-1:0]   i_blk_rdata
);

    localparam int MAX_DEPTH = (RATE_ENTRIES > BLOCK_ENTRIES) ? RATE_ENTRIES : BLOCK_ENTRIES;
    localparam int CLR_AW    = $clog2(MAX_DEPTH);
    localparam int NOW_B     = (TIME_BITS < TICK_W) ? TIME_BITS : TICK_W;
    localparam int CMP_W     = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

    t_state              r_state, n_state;
    logic [CLR_AW-1:0]   r_clr;
    t_in_item            r_item;
    logic [2:0]          r_reason;
    logic [STAT_W-1:0]   r_stat [4];
    logic [SYN_W-1:0]    r_syn;
    logic                r_out_valid;
    t_out_item           r_out;
    logic                r_blk_match, r_blk_exp, r_rate_match, r_rate_exp;

    logic                w_accept, w_out_load;
    logic [TIME_BITS-1:0] w_now;
    // entry fields
    logic                w_blk_valid, w_rate_valid;
    logic [ADDR_W-1:0]   w_blk_tag, w_rate_tag;
    logic [TIME_BITS-1:0] w_blk_start, w_rate_start, w_blk_age, w_rate_age;
    logic [COUNT_W-1:0]  w_rate_cnt;
    // decision
    logic                w_blk_live, w_rate_fresh, w_rate_over, w_judged;
    logic                w_syn_pkt, w_udp_pkt, w_blk_set, w_blk_clr;
    logic [SYN_W-1:0]    w_syn_inc;
    logic [2:0]          w_reason;
    logic [3:0]          w_bump;
    logic [RATE_W-1:0]   w_rate_entry;
    logic [BLK_W-1:0]    w_blk_entry;
    t_out_item           w_out;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_now      = TIME_BITS'(r_item.now_time[NOW_B-1:0]);

    // Unpack table entries
    assign w_blk_valid  = i_blk_rdata[BLK_W-1];
    assign w_blk_tag    = i_blk_rdata[BLK_W-2 -: ADDR_W];
    assign w_blk_start  = i_blk_rdata[TIME_BITS-1:0];
    assign w_rate_valid = i_rate_rdata[RATE_W-1];
    assign w_rate_tag   = i_rate_rdata[RATE_W-2 -: ADDR_W];
    assign w_rate_start = i_rate_rdata[TIME_BITS+COUNT_W-1:COUNT_W];
    assign w_rate_cnt   = i_rate_rdata[COUNT_W-1:0];

    // Ages wrap modulo 2^TIME_BITS
    assign w_blk_age  = w_now - w_blk_start;
    assign w_rate_age = w_now - w_rate_start;

    // Verdict and table updates for the decide cycle
    always_comb begin
        w_blk_live   = r_blk_match && !r_blk_exp;
        w_rate_fresh = !r_rate_match || r_rate_exp;
        w_rate_over  = !w_blk_live && !w_rate_fresh && (w_rate_cnt >= i_cfg.max_per_window);
        w_judged     = !w_blk_live && !w_rate_over;
        w_syn_pkt    = (r_item.protocol == PROTO_TCP) && r_item.tcp_complete
                       && r_item.syn_flag && !r_item.ack_flag;
        w_udp_pkt    = (r_item.protocol == PROTO_UDP);
        w_syn_inc    = (r_syn < SYN_MAX) ? (r_syn + SYN_W'(1)) : r_syn;

        priority if (w_blk_live) begin
            w_reason = REASON_BLOCK;
        end else if (w_rate_over) begin
            w_reason = REASON_RATE;
        end else if (w_syn_pkt && (w_syn_inc > SYN_W'(i_cfg.syn_threshold))) begin
            w_reason = REASON_SYN;
        end else if (w_udp_pkt && (r_item.total_length > i_cfg.udp_length_limit)) begin
            w_reason = REASON_UDP;
        end else begin
            w_reason = REASON_NONE;
        end

        w_bump               = '0;
        w_bump[STAT_TOTAL]   = 1'b1;
        w_bump[STAT_BLOCKED] = w_blk_live || w_rate_over;
        w_bump[STAT_SYN]     = w_judged && w_syn_pkt;
        w_bump[STAT_UDP]     = w_judged && w_udp_pkt;

        w_blk_set = (w_reason == REASON_RATE) || (w_reason == REASON_SYN)
                    || (w_reason == REASON_UDP);
        w_blk_clr = r_blk_match && r_blk_exp;
        w_blk_entry = w_blk_set ? {1'b1, r_item.src_addr, w_now} : '0;

        if (w_rate_fresh) begin
            w_rate_entry = {1'b1, r_item.src_addr, w_now, COUNT_W'(1)};
        end else begin
            w_rate_entry = {1'b1, r_item.src_addr, w_rate_start, w_rate_cnt + COUNT_W'(1)};
        end
    end

    // Result item
    always_comb begin
        w_out.drop        = (r_reason != REASON_NONE);
        w_out.drop_reason = r_reason;
        w_out.stat_value  = (r_item.op == OP_STAT) ? r_stat[r_item.stat_index] : '0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_AW'(MAX_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.op == OP_STAT || !i_in_item.is_ipv4) n_state = ST_DONE;
                    else n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP:  n_state = ST_DEC;
            ST_DEC:  n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_rate_re    = 1'b0;
        o_blk_re     = 1'b0;
        o_rate_we    = 1'b0;
        o_blk_we     = 1'b0;
        o_rate_waddr = i_hash[RATE_AW-1:0];
        o_blk_waddr  = i_hash[BLK_AW-1:0];
        o_rate_wdata = w_rate_entry;
        o_blk_wdata  = w_blk_entry;
        w_out_load   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_rate_we    = 1'b1;
                o_blk_we     = 1'b1;
                o_rate_waddr = r_clr[RATE_AW-1:0];
                o_blk_waddr  = r_clr[BLK_AW-1:0];
                o_rate_wdata = '0;
                o_blk_wdata  = '0;
            end
            ST_IDLE: o_in_ready = 1'b1;
            ST_READ: begin
                o_rate_re = 1'b1;
                o_blk_re  = 1'b1;
            end
            ST_CMP: ;
            ST_DEC: begin
                o_rate_we = w_judged;
                o_blk_we  = w_blk_set || w_blk_clr;
            end
            ST_DONE: w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign o_rate_raddr = i_hash[RATE_AW-1:0];
    assign o_blk_raddr  = i_hash[BLK_AW-1:0];
    assign o_hash_en    = w_accept;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_syn       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) r_stat[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + CLR_AW'(1);
            if (r_state == ST_DEC) begin
                for (int k = 0; k < 4; k++) begin
                    if (w_bump[k] && r_stat[k] != STAT_MAX) r_stat[k] <= r_stat[k] + STAT_W'(1);
                end
                if (w_judged && w_syn_pkt) begin
                    r_syn <= (w_reason == REASON_SYN) ? '0 : w_syn_inc;
                end
            end
            if (w_out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= i_in_item;
            r_reason <= REASON_NONE;
        end
        if (r_state == ST_CMP) begin
            r_blk_match  <= w_blk_valid && (w_blk_tag == r_item.src_addr);
            r_blk_exp    <= CMP_W'(w_blk_age) > CMP_W'(i_cfg.block_ticks);
            r_rate_match <= w_rate_valid && (w_rate_tag == r_item.src_addr);
            r_rate_exp   <= CMP_W'(w_rate_age) > CMP_W'(i_cfg.window_ticks);
        end
        if (r_state == ST_DEC) r_reason <= w_reason;
        if (w_out_load) r_out <= w_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Tables are written only while clearing or deciding
    `PFF_NEVER(a_wr_state, i_clk, i_rst_n, (o_rate_we || o_blk_we) && !(r_state == ST_CLEAR || r_state == ST_DEC), "table write outside clear or decide")
    // Every judged packet advances the total count unless saturated
    `PFF_ASSERT(a_total_bump, i_clk, i_rst_n, (r_state == ST_DEC) |=> (r_stat[STAT_TOTAL] == $past(r_stat[STAT_TOTAL]) + STAT_W'(1) || r_stat[STAT_TOTAL] == STAT_MAX), "total statistic not bumped")
    // A SYN flood verdict restarts the SYN counter
    `PFF_ASSERT(a_syn_reset, i_clk, i_rst_n, (r_state == ST_DEC && w_reason == REASON_SYN) |=> (r_syn == '0), "SYN counter not cleared")
    // No item is taken while the tables are being cleared
    `PFF_NEVER(a_clear_block, i_clk, i_rst_n, w_accept && r_clr != '0 && $past(r_state) == ST_CLEAR && r_state == ST_CLEAR, "item taken during clear")

endmodule

// ----- hdl/packet_flood_filter_top.sv -----
// Packet flood filter top level: config registers, hash stage, two tables, sequencer.
// Depends on pff_pkg, pff_hash, pff_ram, pff_ctrl.
//
//  Channel  Direction  Handshake              Payload
//  in       input      i_in_valid/o_in_ready   i_in_item  (t_in_item)
//  out      output     o_out_valid/i_out_ready o_out_item (t_out_item)
//  cfg      input      i_cfg_we                i_cfg_index, i_cfg_data
//
// A packet item passes hash, table read, age compare, decide/write-back and output load
// in that order; a statistic read or non-IPv4 item goes straight to the output load.
// The read-modify-write of the rate and blocklist RAMs adds the extra packet steps.
// After reset a clearing pass over max(RATE_ENTRIES, BLOCK_ENTRIES) addresses (8192 by
// default) writes every table entry before the first item is taken.
// A waiting result in the output register holds back the result load and the next accept.
module packet_flood_filter_top import pff_pkg::*; #(
    parameter int RATE_ENTRIES  = RATE_ENTRIES_DEF,
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data
);

    localparam int RATE_AW = $clog2(RATE_ENTRIES);
    localparam int BLK_AW  = $clog2(BLOCK_ENTRIES);
    localparam int RATE_W  = 1 + ADDR_W + TIME_BITS + COUNT_W;
    localparam int BLK_W   = 1 + ADDR_W + TIME_BITS;

    t_cfg               r_cfg;
    logic               w_hash_en;
    logic [ADDR_W-1:0]  w_hash;
    logic               w_rate_we, w_rate_re, w_blk_we, w_blk_re;
    logic [RATE_AW-1:0] w_rate_waddr, w_rate_raddr;
    logic [BLK_AW-1:0]  w_blk_waddr, w_blk_raddr;
    logic [RATE_W-1:0]  w_rate_wdata, w_rate_rdata;
    logic [BLK_W-1:0]   w_blk_wdata, w_blk_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_per_window   <= RST_MAX_PER_WINDOW;
            r_cfg.window_ticks     <= RST_WINDOW_TICKS;
            r_cfg.block_ticks      <= RST_BLOCK_TICKS;
            r_cfg.syn_threshold    <= RST_SYN_THRESHOLD;
            r_cfg.udp_length_limit <= RST_UDP_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PER_WINDOW: r_cfg.max_per_window   <= i_cfg_data[COUNT_W-1:0];
                CFG_WINDOW_TICKS:   r_cfg.window_ticks     <= i_cfg_data;
                CFG_BLOCK_TICKS:    r_cfg.block_ticks      <= i_cfg_data;
                CFG_SYN_THRESHOLD:  r_cfg.syn_threshold    <= i_cfg_data[15:0];
                CFG_UDP_LIMIT:      r_cfg.udp_length_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Source hash
    pff_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (w_hash_en),
        .i_src  (i_in_item.src_addr),
        .o_hash (w_hash)
    );

    // Per-source rate window table
    pff_ram #(.DEPTH(RATE_ENTRIES), .WIDTH(RATE_W)) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (w_rate_we),
        .i_waddr (w_rate_waddr),
        .i_wdata (w_rate_wdata),
        .i_re    (w_rate_re),
        .i_raddr (w_rate_raddr),
        .o_rdata (w_rate_rdata)
    );

    // Blocklist table
    pff_ram #(.DEPTH(BLOCK_ENTRIES), .WIDTH(BLK_W)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (w_blk_we),
        .i_waddr (w_blk_waddr),
        .i_wdata (w_blk_wdata),
        .i_re    (w_blk_re),
        .i_raddr (w_blk_raddr),
        .o_rdata (w_blk_rdata)
    );

    pff_ctrl #(
        .RATE_ENTRIES  (RATE_ENTRIES),
        .BLOCK_ENTRIES (BLOCK_ENTRIES),
        .TIME_BITS     (TIME_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item),
        .o_hash_en    (w_hash_en),
        .i_hash       (w_hash),
        .o_rate_we    (w_rate_we),
        .o_rate_waddr (w_rate_waddr),
        .o_rate_wdata (w_rate_wdata),
        .o_rate_re    (w_rate_re),
        .o_rate_raddr (w_rate_raddr),
        .i_rate_rdata (w_rate_rdata),
        .o_blk_we     (w_blk_we),
        .o_blk_waddr  (w_blk_waddr),
        .o_blk_wdata  (w_blk_wdata),
        .o_blk_re     (w_blk_re),
        .o_blk_raddr  (w_blk_raddr),
        .i_blk_rdata  (w_blk_rdata)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for packet_flood_filter_top: directed and random items,
// with every result compared against a flood filter model kept in this file.
// Depends on pff_pkg and the packet_flood_filter_top RTL.
module testbench;
    import pff_pkg::*;

    localparam int RATE_N        = RATE_ENTRIES_DEF;
    localparam int BLOCK_N       = BLOCK_ENTRIES_DEF;
    localparam int POOL_N        = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    // Filter model state
    t_cfg                cfg_model;
    bit                  rate_vld [RATE_N];
    logic [ADDR_W-1:0]   rate_src [RATE_N];
    logic [TICK_W-1:0]   rate_t0  [RATE_N];
    logic [COUNT_W-1:0]  rate_cnt [RATE_N];
    bit                  blk_vld  [BLOCK_N];
    logic [ADDR_W-1:0]   blk_src  [BLOCK_N];
    logic [TICK_W-1:0]   blk_t0   [BLOCK_N];
    logic [SYN_W-1:0]    syn_ctr;
    logic [STAT_W-1:0]   stats [4];

    t_out_item           expected_verdicts [$];
    logic [ADDR_W-1:0]   src_pool [POOL_N];
    logic [TICK_W-1:0]   clock_ticks;
    int                  idle_pct;
    int                  stall_pct;
    int                  mismatch_count;
    int                  cycle_count = 0;

    packet_flood_filter_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10-unit clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------- model

    function automatic logic [ADDR_W-1:0] mix_addr(logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] h;
        h = a * HASH_MULT;
        return h ^ (h >> 16);
    endfunction

    function automatic void count_stat(logic [1:0] k);
        if (stats[k] != STAT_MAX) begin
            stats[k] = stats[k] + 1'b1;
        end
    endfunction

    function automatic void blocklist_source(logic [ADDR_W-1:0] a, logic [TICK_W-1:0] now);
        int unsigned i;
        i = mix_addr(a) % BLOCK_N;
        blk_vld[i] = 1'b1;
        blk_src[i] = a;
        blk_t0[i]  = now;
    endfunction

    // Verdict for one IPv4 packet; updates tables and counters
    function automatic logic [2:0] judge_packet(t_in_item it);
        logic [ADDR_W-1:0] h;
        int unsigned       bi;
        int unsigned       ri;
        logic [TICK_W-1:0] age;
        h  = mix_addr(it.src_addr);
        bi = h % BLOCK_N;
        ri = h % RATE_N;
        count_stat(STAT_TOTAL);

        // blocklist hit, or drop a stale entry
        if (blk_vld[bi] && blk_src[bi] == it.src_addr) begin
            age = it.now_time - blk_t0[bi];
            if (age > cfg_model.block_ticks) begin
                blk_vld[bi] = 1'b0;
            end else begin
                count_stat(STAT_BLOCKED);
                return REASON_BLOCK;
            end
        end

        // fixed window per source
        age = it.now_time - rate_t0[ri];
        if (!(rate_vld[ri] && rate_src[ri] == it.src_addr) || age > cfg_model.window_ticks) begin
            rate_vld[ri] = 1'b1;
            rate_src[ri] = it.src_addr;
            rate_t0[ri]  = it.now_time;
            rate_cnt[ri] = 16'd1;
        end else if (rate_cnt[ri] >= cfg_model.max_per_window) begin
            blocklist_source(it.src_addr, it.now_time);
            count_stat(STAT_BLOCKED);
            return REASON_RATE;
        end else begin
            rate_cnt[ri] = rate_cnt[ri] + 16'd1;
        end

        // SYN flood and UDP size checks
        if (it.protocol == PROTO_TCP) begin
            if (it.tcp_complete && it.syn_flag && !it.ack_flag) begin
                count_stat(STAT_SYN);
                if (syn_ctr != SYN_MAX) begin
                    syn_ctr = syn_ctr + 1'b1;
                end
                if (syn_ctr > cfg_model.syn_threshold) begin
                    blocklist_source(it.src_addr, it.now_time);
                    syn_ctr = '0;
                    return REASON_SYN;
                end
            end
        end else if (it.protocol == PROTO_UDP) begin
            count_stat(STAT_UDP);
            if (it.total_length > cfg_model.udp_length_limit) begin
                blocklist_source(it.src_addr, it.now_time);
                return REASON_UDP;
            end
        end
        return REASON_NONE;
    endfunction

    function automatic t_out_item filter_verdict(t_in_item it);
        t_out_item r;
        r = '0;
        if (it.op == OP_STAT) begin
            r.stat_value = stats[it.stat_index];
        end else if (it.is_ipv4) begin
            r.drop_reason = judge_packet(it);
            r.drop        = (r.drop_reason != REASON_NONE);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [STAT_W-1:0] want,
                                        logic [STAT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result: drop=%0b reason=%0d stat=%0d",
                         $time, out_item.drop, out_item.drop_reason, out_item.stat_value);
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                check_field("drop", STAT_W'(want.drop), STAT_W'(out_item.drop));
                check_field("drop_reason", STAT_W'(want.drop_reason),
                            STAT_W'(out_item.drop_reason));
                check_field("stat_value", want.stat_value, out_item.stat_value);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    // Present one item at the falling edge; valid stays up until a later item or drain
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_verdicts.push_back(filter_verdict(it));
        @(negedge clk);
    endtask

    // Let every outstanding result come back, then wait out the settle period
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(CFG_MAX_PER_WINDOW, TICK_W'(c.max_per_window));
        write_reg(CFG_WINDOW_TICKS, c.window_ticks);
        write_reg(CFG_BLOCK_TICKS, c.block_ticks);
        write_reg(CFG_SYN_THRESHOLD, TICK_W'(c.syn_threshold));
        write_reg(CFG_UDP_LIMIT, TICK_W'(c.udp_length_limit));
        cfg_we    <= 1'b0;
        cfg_model = c;
    endtask

    function automatic t_cfg make_cfg(logic [COUNT_W-1:0] max_pw, logic [TICK_W-1:0] win,
                                      logic [TICK_W-1:0] blk, logic [15:0] syn_th,
                                      logic [15:0] udp_lim);
        t_cfg c;
        c.max_per_window   = max_pw;
        c.window_ticks     = win;
        c.block_ticks      = blk;
        c.syn_threshold    = syn_th;
        c.udp_length_limit = udp_lim;
        return c;
    endfunction

    function automatic t_in_item judge_item(logic [ADDR_W-1:0] src, logic [7:0] proto,
                                            logic tcp_ok, logic syn, logic ack,
                                            logic [15:0] len, logic [TICK_W-1:0] now);
        t_in_item it;
        it.op           = OP_JUDGE;
        it.is_ipv4      = 1'b1;
        it.src_addr     = src;
        it.protocol     = proto;
        it.tcp_complete = tcp_ok;
        it.syn_flag     = syn;
        it.ack_flag     = ack;
        it.total_length = len;
        it.now_time     = now;
        it.stat_index   = 2'($urandom_range(3));
        return it;
    endfunction

    // Statistic read with random filler in the unused fields
    function automatic t_in_item stat_item(logic [1:0] idx);
        t_in_item     it;
        logic [127:0] noise;
        noise         = {$urandom, $urandom, $urandom, $urandom};
        it            = noise[$bits(t_in_item)-1:0];
        it.op         = OP_STAT;
        it.stat_index = idx;
        return it;
    endfunction

    // Random traffic from the source pool; time mostly creeps forward
    task automatic run_traffic(input int n_items, input int max_step, input int syn_pct);
        t_in_item     it;
        logic [127:0] noise;
        for (int k = 0; k < n_items; k++) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            it    = noise[$bits(t_in_item)-1:0];
            it.op      = ($urandom_range(99) < 8) ? OP_STAT : OP_JUDGE;
            it.is_ipv4 = ($urandom_range(99) >= 5);
            if ($urandom_range(99) < 88) begin
                it.src_addr = src_pool[$urandom_range(POOL_N - 1)];
            end
            case ($urandom_range(9))
                0, 1, 2, 3: it.protocol = PROTO_TCP;
                4, 5, 6:    it.protocol = PROTO_UDP;
                default:    ;
            endcase
            it.tcp_complete = ($urandom_range(99) >= 10);
            if ($urandom_range(99) < syn_pct) begin
                it.syn_flag = 1'b1;
                it.ack_flag = 1'b0;
            end
            // lengths around the UDP limit
            if ($urandom_range(99) < 40) begin
                it.total_length = cfg_model.udp_length_limit + 16'($urandom_range(2)) - 16'd1;
            end
            if ($urandom_range(99) < 3) begin
                clock_ticks = {16'($urandom), $urandom};
            end else begin
                clock_ticks = clock_ticks + 48'($urandom_range(max_step));
            end
            it.now_time = clock_ticks;
            send_item(it);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Reset configuration: field extremes, blocklist and UDP drop paths, time wrap, expiry
    task automatic test_directed_cases();
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] c;
        logic [TICK_W-1:0] t;
        t_in_item          it;
        a = 32'h0A00_0001;
        b = 32'h0A00_0002;
        c = 32'hC0A8_0101;
        t = 48'd1000;
        idle_pct  = 0;
        stall_pct = 0;
        send_item(stat_item(STAT_TOTAL));
        send_item(stat_item(STAT_BLOCKED));
        // non-IPv4 passes uncounted
        it         = '1;
        it.op      = OP_JUDGE;
        it.is_ipv4 = 1'b0;
        send_item(it);
        // oversized UDP blocks the source, next packet hits the blocklist
        send_item(judge_item(a, PROTO_UDP, 1'b0, 1'b0, 1'b0, RST_UDP_LIMIT + 16'd1, t));
        send_item(judge_item(a, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd20, t + 1));
        send_item(judge_item(b, PROTO_UDP, 1'b1, 1'b1, 1'b1, RST_UDP_LIMIT, t + 2));
        // TCP: incomplete header, bare SYN, SYN+ACK, ACK
        send_item(judge_item(b, PROTO_TCP, 1'b0, 1'b1, 1'b0, 16'd40, t + 3));
        send_item(judge_item(b, PROTO_TCP, 1'b1, 1'b1, 1'b0, 16'd40, t + 4));
        send_item(judge_item(b, PROTO_TCP, 1'b1, 1'b1, 1'b1, 16'hFFFF, t + 5));
        send_item(judge_item(b, PROTO_TCP, 1'b1, 1'b0, 1'b1, 16'd0, t + 6));
        // other protocols
        send_item(judge_item(b, 8'd1, 1'b1, 1'b1, 1'b0, 16'd64, t + 7));
        send_item(judge_item(b, 8'hFF, 1'b0, 1'b0, 1'b0, 16'hFFFF, t + 8));
        // address and time extremes
        send_item(judge_item(32'h0, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd0, 48'h0));
        send_item(judge_item(32'hFFFF_FFFF, PROTO_TCP, 1'b1, 1'b1, 1'b0, 16'd60, '1));
        // window spanning the time wrap
        send_item(judge_item(c, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd100, 48'hFFFF_FFFF_FFF0));
        send_item(judge_item(c, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd100, 48'h5));
        // blocklist entry at exactly its lifetime, then one tick past
        send_item(judge_item(a, PROTO_TCP, 1'b1, 1'b0, 1'b0, 16'd40, t + RST_BLOCK_TICKS));
        send_item(judge_item(a, PROTO_TCP, 1'b1, 1'b0, 1'b0, 16'd40, t + RST_BLOCK_TICKS + 1));
        send_item(stat_item(STAT_TOTAL));
        send_item(stat_item(STAT_BLOCKED));
        send_item(stat_item(STAT_SYN));
        send_item(stat_item(STAT_UDP));
    endtask

    // Zero packets per window: a repeat inside the window is a rate drop unless still blocklisted
    task automatic test_zero_rate_limit();
        logic [ADDR_W-1:0] p;
        logic [TICK_W-1:0] t;
        p = $urandom;
        t = 48'h7000_0000_0000;
        wait_idle();
        apply_config(make_cfg(16'd0, 48'd100, 48'd30, RST_SYN_THRESHOLD, RST_UDP_LIMIT));
        send_item(judge_item(p, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd64, t));
        send_item(judge_item(p, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd64, t + 1));
        send_item(judge_item(p, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd64, t + 2));
        send_item(judge_item(p, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd64, t + 40));
        send_item(judge_item(p, PROTO_UDP, 1'b0, 1'b0, 1'b0, 16'd64, t + 200));
    endtask

    task automatic test_rate_window();
        wait_idle();
        apply_config(make_cfg(16'd4, 48'd40, 48'd120, 16'd6, 16'd300));
        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(400, 8, 10);
    endtask

    task automatic test_sender_gaps();
        wait_idle();
        apply_config(make_cfg(16'd2, 48'd25, 48'd60, 16'd3, 16'd100));
        idle_pct  = 78;
        stall_pct = 0;
        run_traffic(300, 10, 30);
    endtask

    task automatic test_receiver_stalls();
        wait_idle();
        apply_config(make_cfg(16'd8, 48'd200, 48'd500, 16'd10, 16'd1000));
        idle_pct  = 0;
        stall_pct = 78;
        run_traffic(300, 20, 20);
    endtask

    task automatic test_max_settings();
        wait_idle();
        apply_config(make_cfg(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                              16'hFFFF, 16'hFFFF));
        idle_pct  = 15;
        stall_pct = 15;
        run_traffic(250, 5000, 20);
    endtask

    task automatic test_min_settings();
        wait_idle();
        apply_config(make_cfg(16'd1, 48'd1, 48'd1, 16'd0, 16'd0));
        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(300, 2, 20);
    endtask

    task automatic test_default_settings();
        wait_idle();
        apply_config(make_cfg(RST_MAX_PER_WINDOW, RST_WINDOW_TICKS, RST_BLOCK_TICKS,
                              RST_SYN_THRESHOLD, RST_UDP_LIMIT));
        idle_pct  = 15;
        stall_pct = 15;
        run_traffic(250, 1000000, 30);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [ADDR_W-1:0] cand;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        clock_ticks    = 48'd5000;

        // model at reset
        cfg_model = make_cfg(RST_MAX_PER_WINDOW, RST_WINDOW_TICKS, RST_BLOCK_TICKS,
                             RST_SYN_THRESHOLD, RST_UDP_LIMIT);
        for (int i = 0; i < RATE_N; i++) begin
            rate_vld[i] = 1'b0;
            rate_src[i] = '0;
            rate_t0[i]  = '0;
            rate_cnt[i] = '0;
        end
        for (int i = 0; i < BLOCK_N; i++) begin
            blk_vld[i] = 1'b0;
            blk_src[i] = '0;
            blk_t0[i]  = '0;
        end
        syn_ctr = '0;
        for (int i = 0; i < 4; i++) begin
            stats[i] = '0;
        end

        // source pool: random, plus rate-slot and blocklist-slot collision partners
        for (int i = 0; i < 8; i++) begin
            src_pool[i] = $urandom;
        end
        for (int i = 0; i < 4; i++) begin
            do begin
                cand = $urandom;
            end while (cand == src_pool[i] ||
                       mix_addr(cand) % RATE_N != mix_addr(src_pool[i]) % RATE_N);
            src_pool[8 + i] = cand;
            do begin
                cand = $urandom;
            end while (cand == src_pool[4 + i] ||
                       mix_addr(cand) % BLOCK_N != mix_addr(src_pool[4 + i]) % BLOCK_N);
            src_pool[12 + i] = cand;
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_zero_rate_limit();
        test_rate_window();
        test_sender_gaps();
        test_receiver_stalls();
        test_max_settings();
        test_min_settings();
        test_default_settings();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
